[sv/sorted_sparse_coordinate_table_unit_defines.svh]
// Assertion macros shared by the sorted sparse coordinate table RTL
`ifndef SORTED_SPARSE_COORDINATE_TABLE_UNIT_DEFINES_SVH
`define SORTED_SPARSE_COORDINATE_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define SSCU_ASSERT_NOW(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sscu assertion failed");

// Next-cycle implication, disabled in reset
`define SSCU_ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sscu assertion failed");

`endif

[sv/sscu_pkg.sv]
// Package with beat types and constants of the sorted sparse coordinate table
`default_nettype none

package sscu_pkg;

  localparam int INDEX_BITS = 16;
  localparam int KEY_W      = 2 * INDEX_BITS;
  localparam int VALUE_W    = 32;
  localparam int TOTAL_W    = 9;

  localparam logic [VALUE_W-1:0] QNAN_BITS = 32'h7FC0_0000;

  typedef enum logic {
    MODE_SET = 1'b0,
    MODE_GET = 1'b1
  } mode_t;

  typedef struct packed {
    mode_t                 mode;
    logic [INDEX_BITS-1:0] row_index;
    logic [INDEX_BITS-1:0] col_index;
    logic [VALUE_W-1:0]    value_in;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic [VALUE_W-1:0] value_out;
    logic               status;
    logic [TOTAL_W-1:0] entry_total;
  } out_item_t;

  // One stored matrix entry
  typedef struct packed {
    logic [INDEX_BITS-1:0] row;
    logic [INDEX_BITS-1:0] col;
    logic [VALUE_W-1:0]    value;
  } entry_t;

  // Key compare of the entry just read against the item key
  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_t;

endpackage

`default_nettype wire

[sv/sscu_store.sv]
// Entry memory with registered read and key compare of the read entry
`default_nettype none

module sscu_store #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                 clk,
  input  wire logic                 rd_en,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  input  wire logic                 wr_en,
  input  wire logic [ADDR_W-1:0]    wr_addr,
  input  wire sscu_pkg::entry_t     wr_data,
  input  wire logic [sscu_pkg::KEY_W-1:0] key,
  output sscu_pkg::entry_t          rd_data,
  output sscu_pkg::cmp_t            cmp
);
  import sscu_pkg::*;

  entry_t mem [DEPTH];
  logic [KEY_W-1:0] entry_key;

  // Write one entry, read one entry per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Compare the read entry with the item key in row-major order
  assign entry_key = {rd_data.row, rd_data.col};
  assign cmp       = '{ge: (entry_key >= key), eq: (entry_key == key)};

endmodule

`default_nettype wire

[sv/sorted_sparse_coordinate_table_unit.sv]
// Sorted sparse coordinate table: (row, column, value) entries in row-major order
// One item at a time. Entries live in a single memory with one read and one
// write port and a registered read. A lookup streams entries from slot 0,
// one per cycle, and stops at the first entry not below the key; an insert then
// moves every later entry up one slot, one per cycle, and writes the new entry.
// A new item is taken while the previous result still waits in the output
// register. No clearing pass is needed after reset: only slots below the entry
// count are ever read.
`default_nettype none
`include "sorted_sparse_coordinate_table_unit_defines.svh"

module sorted_sparse_coordinate_table_unit #(
  parameter int MAX_ENTRIES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire sscu_pkg::in_item_t  item,
  output logic                     result_valid,
  input  wire logic                result_stall,
  output sscu_pkg::out_item_t      result
);
  import sscu_pkg::*;

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SCAN   = 6'b000010,
    ST_DECIDE = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_APPLY  = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  in_item_t         cur;
  logic [CNT_W-1:0] ptr;
  logic [CNT_W-1:0] ptr_dec;
  logic [CNT_W-1:0] rd_idx;
  logic             rd_pend;
  logic [CNT_W-1:0] pos;
  logic             found;
  logic             wr_pend;
  logic [ADDR_W-1:0] wr_addr;
  out_item_t        pend;
  out_item_t        res;
  logic             res_valid;

  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  entry_t            mem_wdata;
  entry_t            mem_q;
  cmp_t              cmp;
  logic              scan_more;
  logic              shift_more;
  logic              full;

  assign ptr_dec    = ptr - 1'b1;
  assign scan_more  = (ptr < count);
  assign shift_more = (ptr > pos);
  assign full       = (count == CNT_W'(MAX_ENTRIES));

  assign item_stall   = (state != ST_IDLE);
  assign result_valid = res_valid;
  assign result       = res;

  sscu_store #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .key     ({cur.row_index, cur.col_index}),
    .rd_data (mem_q),
    .cmp     (cmp)
  );

  // Drive the memory port from the sequencer state
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = ptr[ADDR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = wr_addr;
    mem_wdata = mem_q;
    unique case (state)
      ST_SCAN: begin
        mem_re = !(rd_pend && cmp.ge) && scan_more;
      end
      ST_SHIFT: begin
        mem_we    = wr_pend;
        mem_re    = shift_more;
        mem_raddr = ptr_dec[ADDR_W-1:0];
      end
      ST_APPLY: begin
        mem_we    = 1'b1;
        mem_waddr = pos[ADDR_W-1:0];
        mem_wdata = '{row: cur.row_index, col: cur.col_index, value: cur.value_in};
      end
      default: begin
      end
    endcase
  end

  // Sequence one item: scan, decide, shift (inserts only), write (sets only), deliver
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rd_pend   <= 1'b0;
      wr_pend   <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (res_valid && !result_stall && state != ST_FINISH) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            cur     <= item;
            ptr     <= '0;
            rd_pend <= 1'b0;
            state   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (rd_pend && cmp.ge) begin
            pos     <= rd_idx;
            found   <= cmp.eq;
            rd_pend <= 1'b0;
            state   <= ST_DECIDE;
          end else if (scan_more) begin
            rd_pend <= 1'b1;
            rd_idx  <= ptr;
            ptr     <= ptr + 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              pos   <= count;
              found <= 1'b0;
              state <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          pend.hit         <= found;
          pend.value_out   <= (cur.mode == MODE_GET) ? (found ? mem_q.value : QNAN_BITS) : '0;
          pend.status      <= (cur.mode == MODE_SET) && !found && full;
          pend.entry_total <= TOTAL_W'(count);
          unique case (cur.mode)
            MODE_GET: begin
              state <= ST_FINISH;
            end
            MODE_SET: begin
              priority if (found) begin
                state <= ST_APPLY;
              end else if (full) begin
                state <= ST_FINISH;
              end else begin
                ptr     <= count;
                wr_pend <= 1'b0;
                state   <= ST_SHIFT;
              end
            end
            default: begin
              state <= ST_FINISH;
            end
          endcase
        end
        ST_SHIFT: begin
          // move entry ptr-1 up to slot ptr, one per cycle
          if (shift_more) begin
            wr_addr <= ptr[ADDR_W-1:0];
            wr_pend <= 1'b1;
            ptr     <= ptr_dec;
          end else begin
            wr_pend <= 1'b0;
            if (!wr_pend) begin
              state <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (!found) begin
            count            <= count + 1'b1;
            pend.entry_total <= TOTAL_W'(count + 1'b1);
          end
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (!res_valid || !result_stall) begin
            res       <= pend;
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer and the memory traffic
  `SSCU_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(MAX_ENTRIES))
  `SSCU_ASSERT_NOW(a_write_states, clk, rst, mem_we, state == ST_SHIFT || state == ST_APPLY)
  `SSCU_ASSERT_NOW(a_scan_in_range, clk, rst, mem_re && state == ST_SCAN, ptr < count)
  `SSCU_ASSERT_NOW(a_refuse_full, clk, rst, res_valid && res.status, full)

endmodule

`default_nettype wire

[sim/sscu_test_pkg.sv]
// Scoreboard class that tracks the coordinate table and checks its result beats
package sscu_test_pkg;

  import sscu_pkg::*;

  localparam int TABLE_SLOTS = 256;
  localparam int SHOWN_MISMATCHES = 10;

  class coo_table_tracker;

    logic [INDEX_BITS-1:0] row_at [TABLE_SLOTS];
    logic [INDEX_BITS-1:0] col_at [TABLE_SLOTS];
    logic [VALUE_W-1:0]    value_at [TABLE_SLOTS];
    int unsigned           count;
    out_item_t             lookup_replies [$];
    int unsigned           mismatches;
    int unsigned           checked;
    int unsigned           refused;
    int unsigned           get_hits;
    int unsigned           get_misses;
    int unsigned           updates;

    function new();
      count = 0;
      mismatches = 0;
      checked = 0;
      refused = 0;
      get_hits = 0;
      get_misses = 0;
      updates = 0;
    endfunction

    function int unsigned pending();
      return lookup_replies.size();
    endfunction

    // Apply one accepted item to the table copy and queue the reply it owes
    function void apply_item(in_item_t it);
      int unsigned slot;
      int unsigned i;
      bit          found;
      out_item_t   reply;
      slot = 0;
      while (slot < count &&
             {row_at[slot], col_at[slot]} < {it.row_index, it.col_index})
        slot++;
      found = (slot < count) &&
              ({row_at[slot], col_at[slot]} == {it.row_index, it.col_index});
      reply = '0;
      reply.hit = found;
      if (it.mode == MODE_GET) begin
        reply.value_out = found ? value_at[slot] : QNAN_BITS;
        if (found) get_hits++;
        else get_misses++;
      end else if (found) begin
        value_at[slot] = it.value_in;
        updates++;
      end else if (count >= TABLE_SLOTS) begin
        reply.status = 1'b1;
        refused++;
      end else begin
        // Shift later entries up one slot, then drop the new one in place
        for (i = count; i > slot; i--) begin
          row_at[i] = row_at[i-1];
          col_at[i] = col_at[i-1];
          value_at[i] = value_at[i-1];
        end
        row_at[slot] = it.row_index;
        col_at[slot] = it.col_index;
        value_at[slot] = it.value_in;
        count++;
      end
      reply.entry_total = TOTAL_W'(count);
      lookup_replies.insert(lookup_replies.size(), reply);
    endfunction

    // Compare one result beat with the oldest owed reply
    function void check_result(out_item_t got);
      out_item_t want;
      checked++;
      if (lookup_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("ERROR: unowed beat: hit=%0b value=%08h st=%0b total=%0d",
                   got.hit, got.value_out, got.status, got.entry_total);
        return;
      end
      want = lookup_replies.pop_front();
      if (got.hit !== want.hit || got.value_out !== want.value_out ||
          got.status !== want.status || got.entry_total !== want.entry_total) begin
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
          $display("ERROR: beat %0d exp %0b/%08h/%0b/%0d got %0b/%08h/%0b/%0d",
                   checked, want.hit, want.value_out, want.status, want.entry_total,
                   got.hit, got.value_out, got.status, got.entry_total);
      end
    endfunction

  endclass

endpackage

[sim/sorted_sparse_coordinate_table_unit_test.sv]
// Top-level testbench of the sorted sparse coordinate table unit
module sorted_sparse_coordinate_table_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import sscu_pkg::*;
  import sscu_test_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int TAIL_CYCLES = 600;
  localparam int HOLD_CYCLES = 3000;
  localparam int ITEM_TARGET = 1150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_stall;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_stall = 1'b0;
  out_item_t result;

  coo_table_tracker tracker = new();

  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          hold_request = 0;
  int          hold_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  logic [KEY_W-1:0] known_keys [$];

  sorted_sparse_coordinate_table_unit #(
    .MAX_ENTRIES(TABLE_SLOTS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .item        (item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result      (result)
  );

  // Free-running clock, 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort the run if it hangs
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sorted_sparse_coordinate_table_unit verification failed");
      $finish;
    end
  end

  // Check result beats, then pick the stall for the next cycle
  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall)
      tracker.check_result(result);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // Offer one beat after a random idle gap and hold it until accepted
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    tracker.apply_item(it);
    items_sent++;
  endtask

  task automatic send_coord(mode_t mode, logic [INDEX_BITS-1:0] row,
                            logic [INDEX_BITS-1:0] col, logic [VALUE_W-1:0] value);
    in_item_t it;
    it.mode = mode;
    it.row_index = row;
    it.col_index = col;
    it.value_in = value;
    if (mode == MODE_SET) known_keys.insert(known_keys.size(), {row, col});
    send_item(it);
  endtask

  // Build a random item, reusing a stored coordinate part of the time
  function automatic in_item_t random_item(int set_pct, int known_pct);
    in_item_t it;
    int       pick;
    it.mode = ($urandom_range(0, 99) < set_pct) ? MODE_SET : MODE_GET;
    if (known_keys.size() > 0 && $urandom_range(0, 99) < known_pct) begin
      pick = $urandom_range(0, known_keys.size() - 1);
      {it.row_index, it.col_index} = known_keys[pick];
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          it.row_index = INDEX_BITS'($urandom_range(0, 3));
          it.col_index = INDEX_BITS'($urandom);
        end
        1: begin
          it.row_index = INDEX_BITS'($urandom);
          it.col_index = $urandom_range(0, 1) ? '1 : '0;
        end
        default: begin
          it.row_index = INDEX_BITS'($urandom);
          it.col_index = INDEX_BITS'($urandom);
        end
      endcase
      if (it.mode == MODE_SET)
        known_keys.insert(known_keys.size(), {it.row_index, it.col_index});
    end
    case ($urandom_range(0, 7))
      0: it.value_in = '0;
      1: it.value_in = '1;
      2: it.value_in = QNAN_BITS;
      default: it.value_in = $urandom;
    endcase
    return it;
  endfunction

  task automatic run_random(int n, int set_pct, int known_pct);
    repeat (n) send_item(random_item(set_pct, known_pct));
  endtask

  // Stop offering and wait until every owed reply has come back
  task automatic drain();
    item_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int guard;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty lookup, extremes, updates, middle inserts
    send_coord(MODE_GET, 16'h0000, 16'h0000, 32'hDEAD_BEEF);
    send_coord(MODE_SET, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_coord(MODE_SET, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_coord(MODE_GET, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_coord(MODE_GET, 16'h0000, 16'h0000, 32'h0000_0000);
    send_coord(MODE_SET, 16'h0000, 16'h0000, 32'h1234_5678);
    send_coord(MODE_GET, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
    send_coord(MODE_SET, 16'h0000, 16'hFFFF, 32'hA5A5_A5A5);
    send_coord(MODE_SET, 16'hFFFF, 16'h0000, 32'h5A5A_5A5A);
    send_coord(MODE_SET, 16'h8000, 16'h8000, QNAN_BITS);
    send_coord(MODE_GET, 16'h8000, 16'h8000, 32'h0000_0000);
    send_coord(MODE_GET, 16'h8000, 16'h8001, 32'h0000_0000);
    send_coord(MODE_GET, 16'h7FFF, 16'hFFFF, 32'h0000_0000);
    send_coord(MODE_SET, 16'h0001, 16'h0000, 32'h0000_0001);
    send_coord(MODE_GET, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_coord(MODE_GET, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_coord(MODE_SET, 16'hFFFF, 16'hFFFF, 32'h8000_0000);
    send_coord(MODE_GET, 16'hFFFF, 16'hFFFF, 32'h0000_0000);
    send_coord(MODE_SET, 16'h5555, 16'hAAAA, 32'h5555_5555);
    send_coord(MODE_SET, 16'hAAAA, 16'h5555, 32'hAAAA_AAAA);
    send_coord(MODE_GET, 16'h5555, 16'hAAAA, 32'h0000_0000);
    send_coord(MODE_GET, 16'h0001, 16'h0000, 32'h0000_0000);

    // No idling on either side
    run_random(230, 60, 50);
    drain();

    // Sender mostly idle
    tx_idle_pct = 85;
    run_random(180, 60, 50);

    // Receiver holds off for a long stretch while the sender keeps offering
    tx_idle_pct = 0;
    rx_stall_pct = 85;
    hold_request = HOLD_CYCLES;
    run_random(180, 60, 50);
    drain();

    // Fill the table with mostly fresh coordinates, then try inserts, updates and gets on a full table
    rx_stall_pct = 0;
    guard = 0;
    while (tracker.count < TABLE_SLOTS && guard < 600) begin
      send_item(random_item(95, 5));
      guard++;
    end
    run_random(12, 100, 0);
    run_random(12, 100, 100);
    run_random(12, 0, 50);

    // Both sides idle now and then
    tx_idle_pct = 9;
    rx_stall_pct = 9;
    if (items_sent + 50 < ITEM_TARGET) run_random(ITEM_TARGET - items_sent, 50, 50);
    else run_random(50, 50, 50);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d items: %0d updates, %0d get hits, %0d get misses, %0d refused inserts",
             items_sent, tracker.updates, tracker.get_hits, tracker.get_misses, tracker.refused);
    $display("Checked %0d result beats, table ended with %0d entries, %0d mismatches",
             tracker.checked, tracker.count, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("sorted_sparse_coordinate_table_unit verification clean");
    end else begin
      $display("sorted_sparse_coordinate_table_unit verification failed");
    end
    $finish;
  end

endmodule
